// File: hdl/dspc_pkg.sv
package dspc_pkg;

   localparam int MICROSTEPS_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;

   localparam int RATE_SCALE      = 1000;
   localparam int RATE_MIN_Q16    = 943718;
   localparam int RATE_HIGH_Q16   = 229 * 65536;
   localparam int PERIOD_NUM_HIGH = 15000000;
   localparam int PERIOD_NUM_LOW  = 937500;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   localparam logic [2:0] STATUS_NONE     = 3'd0;
   localparam logic [2:0] STATUS_FINISHED = 3'd1;
   localparam logic [2:0] STATUS_ENDSTOP  = 3'd2;
   localparam logic [2:0] STATUS_MANUAL   = 3'd3;
   localparam logic [2:0] STATUS_REFUSED  = 3'd4;

   localparam logic CSR_COEF   = 1'b0;
   localparam logic CSR_INVERT = 1'b1;

   typedef enum logic [1:0] {
      CLS_NONE  = 2'd0,
      CLS_START = 2'd1,
      CLS_TICK  = 2'd2,
      CLS_STOP  = 2'd3
   } cls_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        refill;
      logic [31:0] flow_rate;
      logic [31:0] dose_volume;
      logic        forward_endstop_level;
      logic        backward_endstop_level;
   } req_type;

   typedef struct packed {
      logic        step_pulse;
      logic        direction_level;
      logic        driver_disable;
      logic        busy_res;
      logic [2:0]  job_status;
      logic [31:0] steps_done;
   } rsp_type;

   typedef struct packed {
      cls_type cls;
      req_type req;
   } item_type;

   typedef struct packed {
      logic        go;
      logic [31:0] coef;
      logic [31:0] flow;
      logic [31:0] vol;
   } calc_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] limit;
      logic [15:0] period;
   } calc_rsp_type;

endpackage

// File: hdl/dspc_front.sv
module dspc_front import dspc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     pop,
   output logic     head_valid,
   output item_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               do_pop;
   item_type           entry;

   always_comb begin
      entry.req = req_data;
      unique case (req_data.kind)
         KIND_START: entry.cls = CLS_START;
         KIND_TICK:  entry.cls = CLS_TICK;
         KIND_STOP:  entry.cls = CLS_STOP;
         default:    entry.cls = CLS_NONE;
      endcase
   end

   assign req_stall  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// File: hdl/dspc_calc.sv
module dspc_calc import dspc_pkg::*; #(
   parameter int MICROSTEPS = MICROSTEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  calc_req_type calc_req,
   output calc_rsp_type calc_rsp
);

   localparam int RATE_MUL = MICROSTEPS * RATE_SCALE;
   localparam int DM_W     = $clog2(RATE_MUL + 1);
   localparam int MS_W     = $clog2(MICROSTEPS + 1);
   localparam int RATE_W   = 40 + DM_W;
   localparam int LO_W     = 24 + DM_W;
   localparam int LIM_W    = 33 + MS_W;
   localparam int QUOT_W   = 17;
   localparam int DIV_W    = RATE_W + QUOT_W;
   localparam int QBIT_W   = $clog2(QUOT_W);

   typedef enum logic [7:0] {
      CS_IDLE = 8'b0000_0001,
      CS_MULV = 8'b0000_0010,
      CS_MULF = 8'b0000_0100,
      CS_MULR = 8'b0000_1000,
      CS_SUM  = 8'b0001_0000,
      CS_PREP = 8'b0010_0000,
      CS_DIV  = 8'b0100_0000,
      CS_DONE = 8'b1000_0000
   } cstate_type;

   cstate_type          state_ff, state_in;
   logic [31:0]         coef_ff, coef_in;
   logic [31:0]         flow_ff, flow_in;
   logic [31:0]         vol_ff, vol_in;
   logic [63:0]         prod_ff, prod_in;
   logic [31:0]         limit_ff, limit_in;
   logic [RATE_W-1:0]   hi_ff, hi_in;
   logic [LO_W-1:0]     lo_ff, lo_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [QBIT_W-1:0]   bit_ff, bit_in;

   logic [31:0]         mul_b;
   logic [63:0]         mul_out;
   logic [24:0]         whole;
   logic [LIM_W-1:0]    lim_full;
   logic [RATE_W-1:0]   rate_sum;
   logic [23:0]         num;
   logic                ge;

   assign mul_b    = (state_ff == CS_MULF) ? flow_ff : vol_ff;
   assign mul_out  = 64'(coef_ff) * 64'(mul_b);
   assign whole    = 25'(prod_ff[63:40]) + 25'(prod_ff[39]);
   assign lim_full = LIM_W'(whole) * LIM_W'(MICROSTEPS);
   assign rate_sum = hi_ff + RATE_W'(lo_ff[LO_W-1:24]);
   assign num      = (rate_ff >= RATE_W'(RATE_HIGH_Q16)) ? 24'(PERIOD_NUM_HIGH)
                                                         : 24'(PERIOD_NUM_LOW);
   assign ge       = (rem_ff >= div_ff);

   always_comb begin
      state_in = state_ff;
      coef_in  = coef_ff;
      flow_in  = flow_ff;
      vol_in   = vol_ff;
      prod_in  = prod_ff;
      limit_in = limit_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      rate_in  = rate_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quot_in  = quot_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (calc_req.go) begin
               coef_in  = calc_req.coef;
               flow_in  = calc_req.flow;
               vol_in   = calc_req.vol;
               state_in = CS_MULV;
            end
         end
         CS_MULV: begin
            prod_in  = mul_out;
            state_in = CS_MULF;
         end
         CS_MULF: begin
            limit_in = (|lim_full[LIM_W-1:32]) ? 32'hFFFF_FFFF : lim_full[31:0];
            prod_in  = mul_out;
            state_in = CS_MULR;
         end
         CS_MULR: begin
            hi_in    = RATE_W'(prod_ff[63:24]) * RATE_W'(RATE_MUL);
            lo_in    = LO_W'(prod_ff[23:0]) * LO_W'(RATE_MUL);
            state_in = CS_SUM;
         end
         CS_SUM: begin
            rate_in  = (rate_sum < RATE_W'(RATE_MIN_Q16)) ? RATE_W'(RATE_MIN_Q16) : rate_sum;
            state_in = CS_PREP;
         end
         CS_PREP: begin
            rem_in   = (DIV_W'(num) << 16) + DIV_W'(rate_ff >> 1);
            div_in   = DIV_W'(rate_ff) << (QUOT_W - 1);
            quot_in  = '0;
            bit_in   = QBIT_W'(QUOT_W - 1);
            state_in = CS_DIV;
         end
         CS_DIV: begin
            if (ge) begin
               rem_in = rem_ff - div_ff;
            end
            quot_in = {quot_ff[QUOT_W-2:0], ge};
            div_in  = div_ff >> 1;
            if (bit_ff == '0) begin
               state_in = CS_DONE;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         CS_DONE: begin
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      calc_rsp.done  = (state_ff == CS_DONE);
      calc_rsp.limit = limit_ff;
      if (quot_ff == '0) begin
         calc_rsp.period = 16'd1;
      end else if (quot_ff[QUOT_W-1]) begin
         calc_rsp.period = 16'hFFFF;
      end else begin
         calc_rsp.period = quot_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff  <= coef_in;
      flow_ff  <= flow_in;
      vol_ff   <= vol_in;
      prod_ff  <= prod_in;
      limit_ff <= limit_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      rate_ff  <= rate_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quot_ff  <= quot_in;
      bit_ff   <= bit_in;
   end

endmodule

// File: hdl/dspc_back.sv
module dspc_back import dspc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  item_type     head,
   output logic         pop,
   input  logic [31:0]  coef,
   input  logic         invert,
   output calc_req_type calc_req,
   input  calc_rsp_type calc_rsp,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_CALC = 3'b010,
      BK_EMIT = 3'b100
   } bstate_type;

   bstate_type   state_ff, state_in;
   logic         running_ff, running_in;
   logic         backward_ff, backward_in;
   logic [31:0]  count_ff, count_in;
   logic [31:0]  limit_ff, limit_in;
   logic [15:0]  period_ff, period_in;
   logic [15:0]  cd_ff, cd_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic         out_free;
   logic         emit;
   logic         pulse;
   logic [2:0]   status;
   logic         stop_lvl;
   logic         step_lvl;
   logic [31:0]  count_inc;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign stop_lvl  = head.req.refill ? head.req.backward_endstop_level
                                      : head.req.forward_endstop_level;
   assign step_lvl  = backward_ff ? head.req.backward_endstop_level
                                  : head.req.forward_endstop_level;
   assign count_inc = count_ff + 32'd1;

   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      backward_in   = backward_ff;
      count_in      = count_ff;
      limit_in      = limit_ff;
      period_in     = period_ff;
      cd_in         = cd_ff;
      pop           = 1'b0;
      calc_req.go   = 1'b0;
      calc_req.coef = coef;
      calc_req.flow = head.req.flow_rate;
      calc_req.vol  = head.req.dose_volume;
      emit          = 1'b0;
      pulse         = 1'b0;
      status        = STATUS_NONE;
      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid && out_free) begin
               pop = 1'b1;
               unique case (head.cls)
                  CLS_START: begin
                     if (running_ff) begin
                        emit = 1'b1;
                     end else if (!stop_lvl) begin
                        emit   = 1'b1;
                        status = STATUS_REFUSED;
                     end else begin
                        backward_in = head.req.refill;
                        calc_req.go = 1'b1;
                        state_in    = BK_CALC;
                     end
                  end
                  CLS_TICK: begin
                     emit = 1'b1;
                     if (running_ff) begin
                        if (cd_ff <= 16'd1) begin
                           pulse    = 1'b1;
                           count_in = count_inc;
                           cd_in    = period_ff;
                           if (count_inc >= limit_ff) begin
                              running_in = 1'b0;
                              status     = STATUS_FINISHED;
                           end else if (!step_lvl) begin
                              running_in = 1'b0;
                              status     = STATUS_ENDSTOP;
                           end
                        end else begin
                           cd_in = cd_ff - 16'd1;
                        end
                     end
                  end
                  CLS_STOP: begin
                     emit = 1'b1;
                     if (running_ff) begin
                        running_in = 1'b0;
                        status     = STATUS_MANUAL;
                     end
                  end
                  CLS_NONE: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         BK_CALC: begin
            if (calc_rsp.done) begin
               limit_in  = calc_rsp.limit;
               period_in = calc_rsp.period;
               state_in  = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               emit       = 1'b1;
               count_in   = '0;
               cd_in      = period_ff;
               running_in = (limit_ff != '0);
               status     = (limit_ff == '0) ? STATUS_FINISHED : STATUS_NONE;
               state_in   = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in.step_pulse      = pulse;
      rsp_data_in.direction_level = backward_in ^ ~invert;
      rsp_data_in.driver_disable  = ~running_in;
      rsp_data_in.busy_res        = running_in;
      rsp_data_in.job_status      = status;
      rsp_data_in.steps_done      = count_in;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         running_ff   <= 1'b0;
         backward_ff  <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= '0;
         period_ff    <= 16'd1;
         cd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         backward_ff  <= backward_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         period_ff    <= period_in;
         cd_ff        <= cd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: hdl/dosing_step_pulse_controller_top.sv
// channel    ports                          moves
// request    req_valid req_stall req_data   start, tick or stop request
// response   rsp_valid rsp_stall rsp_data   one response per request
// csr        csr_valid csr_ready csr_index  coefficient and direction invert
//            csr_data
// Tick and stop requests are handled in the back end's idle state without the calculator,
// back to back while the response is free; a start request runs through the 17-step period divider.
// A two-entry queue sits between request intake and execution.
// Reset is synchronous, active high; csr writes are always taken.
// A stalled response holds while the queue takes requests until it is full.
module dosing_step_pulse_controller_top import dspc_pkg::*; #(
   parameter int MICROSTEPS = MICROSTEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0]  coef_ff, coef_in;
   logic         invert_ff, invert_in;
   logic         head_valid;
   item_type     head;
   logic         pop;
   calc_req_type calc_req;
   calc_rsp_type calc_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      coef_in   = coef_ff;
      invert_in = invert_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COEF:   coef_in   = csr_data;
            CSR_INVERT: invert_in = csr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         invert_ff <= 1'b1;
      end else begin
         coef_ff   <= coef_in;
         invert_ff <= invert_in;
      end
   end

   dspc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   dspc_calc #(
      .MICROSTEPS (MICROSTEPS)
   ) u_calc (
      .clock    (clock),
      .reset    (reset),
      .calc_req (calc_req),
      .calc_rsp (calc_rsp)
   );

   dspc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .coef       (coef_ff),
      .invert     (invert_ff),
      .calc_req   (calc_req),
      .calc_rsp   (calc_rsp),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: tb/tb_dosing_step_pulse_controller_top.sv
`timescale 1ns / 1ps

module tb_dosing_step_pulse_controller_top;
   import dspc_pkg::*;

   localparam logic [1:0]  KIND_UNUSED   = 2'd3;
   localparam logic [31:0] COEF_ONE      = 32'h0100_0000;
   localparam logic [31:0] COEF_MAX      = 32'hFFFF_FFFF;
   localparam logic [31:0] COEF_SIXTEENTH = 32'h0010_0000;
   localparam logic [31:0] Q16_MAX       = 32'hFFFF_FFFF;
   localparam logic [31:0] Q16_HALF      = 32'h0000_8000;
   localparam logic [31:0] Q16_ONE       = 32'h0001_0000;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          WATCHDOG_LIMIT = 5000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   dosing_step_pulse_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // pump model state
   logic [31:0] cfg_coef;
   logic        cfg_invert;
   logic        run_active;
   logic        run_backward;
   logic [31:0] step_cnt;
   logic [31:0] step_lim;
   logic [15:0] step_per;
   logic [15:0] tick_left;

   rsp_type expected_rsp_q[$];
   int      error_count;
   int      requests_sent;
   int      send_idle_pct;
   int      recv_stall_pct;
   int      quiet_cycles;

   function automatic logic [31:0] dose_step_limit(logic [31:0] coef, logic [31:0] vol);
      logic [63:0] prod;
      logic [63:0] whole;
      logic [63:0] lim;
      prod  = {32'd0, coef} * {32'd0, vol};
      whole = (prod >> 40) + {63'd0, prod[39]};
      lim   = whole * MICROSTEPS_DEF;
      if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
      return lim[31:0];
   endfunction

   function automatic logic [15:0] step_period_for(logic [31:0] coef, logic [31:0] flow);
      logic [63:0] prod;
      logic [63:0] scale;
      logic [63:0] rate;
      logic [63:0] num;
      logic [63:0] per;
      prod  = {32'd0, coef} * {32'd0, flow};
      scale = 64'(MICROSTEPS_DEF * RATE_SCALE);
      rate  = (prod >> 24) * scale + (((prod & 64'hFF_FFFF) * scale) >> 24);
      if (rate < 64'(RATE_MIN_Q16)) rate = 64'(RATE_MIN_Q16);
      num = (rate >= 64'(RATE_HIGH_Q16)) ? 64'(PERIOD_NUM_HIGH) : 64'(PERIOD_NUM_LOW);
      per = ((num << 16) + (rate >> 1)) / rate;
      if (per < 64'd1) per = 64'd1;
      if (per > 64'd65535) per = 64'd65535;
      return per[15:0];
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type    o;
      logic [2:0] status;
      logic       stop_lvl;
      status = STATUS_NONE;
      o      = '0;
      case (r.kind)
         KIND_START: begin
            if (!run_active) begin
               stop_lvl = r.refill ? r.backward_endstop_level : r.forward_endstop_level;
               if (!stop_lvl) begin
                  status = STATUS_REFUSED;
               end else begin
                  run_backward = r.refill;
                  step_lim     = dose_step_limit(cfg_coef, r.dose_volume);
                  step_per     = step_period_for(cfg_coef, r.flow_rate);
                  tick_left    = step_per;
                  step_cnt     = '0;
                  if (step_lim == 0) status = STATUS_FINISHED;
                  else run_active = 1'b1;
               end
            end
         end
         KIND_TICK: begin
            if (run_active) begin
               if (tick_left <= 16'd1) begin
                  stop_lvl     = run_backward ? r.backward_endstop_level
                                              : r.forward_endstop_level;
                  o.step_pulse = 1'b1;
                  step_cnt     = step_cnt + 32'd1;
                  tick_left    = step_per;
                  if (step_cnt >= step_lim) begin
                     run_active = 1'b0;
                     status     = STATUS_FINISHED;
                  end else if (!stop_lvl) begin
                     run_active = 1'b0;
                     status     = STATUS_ENDSTOP;
                  end
               end else begin
                  tick_left = tick_left - 16'd1;
               end
            end
         end
         KIND_STOP: begin
            if (run_active) begin
               run_active = 1'b0;
               status     = STATUS_MANUAL;
            end
         end
         default: ;
      endcase
      o.direction_level = run_backward ^ ~cfg_invert;
      o.driver_disable  = ~run_active;
      o.busy_res        = run_active;
      o.job_status      = status;
      o.steps_done      = step_cnt;
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] kind, logic refill, logic [31:0] flow,
                                        logic [31:0] vol, logic fwd, logic bwd);
      req_type r;
      r.kind                   = kind;
      r.refill                 = refill;
      r.flow_rate              = flow;
      r.dose_volume            = vol;
      r.forward_endstop_level  = fwd;
      r.backward_endstop_level = bwd;
      return r;
   endfunction

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            error_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_data.step_pulse !== exp_rsp.step_pulse) begin
               $error("step_pulse: expected %0d, got %0d",
                      exp_rsp.step_pulse, rsp_data.step_pulse);
               error_count++;
            end
            if (rsp_data.direction_level !== exp_rsp.direction_level) begin
               $error("direction_level: expected %0d, got %0d",
                      exp_rsp.direction_level, rsp_data.direction_level);
               error_count++;
            end
            if (rsp_data.driver_disable !== exp_rsp.driver_disable) begin
               $error("driver_disable: expected %0d, got %0d",
                      exp_rsp.driver_disable, rsp_data.driver_disable);
               error_count++;
            end
            if (rsp_data.busy_res !== exp_rsp.busy_res) begin
               $error("busy_res: expected %0d, got %0d",
                      exp_rsp.busy_res, rsp_data.busy_res);
               error_count++;
            end
            if (rsp_data.job_status !== exp_rsp.job_status) begin
               $error("job_status: expected %0d, got %0d",
                      exp_rsp.job_status, rsp_data.job_status);
               error_count++;
            end
            if (rsp_data.steps_done !== exp_rsp.steps_done) begin
               $error("steps_done: expected %0d, got %0d",
                      exp_rsp.steps_done, rsp_data.steps_done);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp_q.push_back(predict_response(r));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_COEF) cfg_coef = value;
      else cfg_invert = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_idle_requests();
      send_request(make_req(KIND_TICK, 1'b0, Q16_MAX, Q16_MAX, 1'b0, 1'b0));
      send_request(make_req(KIND_STOP, 1'b1, '0, '0, 1'b1, 1'b1));
      send_request(make_req(KIND_UNUSED, 1'b1, Q16_MAX, '0, 1'b1, 1'b0));
   endtask

   task automatic test_refused_starts();
      send_request(make_req(KIND_START, 1'b0, Q16_ONE, Q16_ONE, 1'b0, 1'b1));
      send_request(make_req(KIND_START, 1'b1, Q16_ONE, Q16_ONE, 1'b1, 1'b0));
   endtask

   task automatic test_zero_limit();
      send_request(make_req(KIND_START, 1'b0, Q16_MAX, Q16_MAX, 1'b1, 1'b1));
   endtask

   // limit reached on the same step that sees the endstop: finished wins
   task automatic test_limit_with_endstop();
      send_request(make_req(KIND_START, 1'b0, Q16_MAX, Q16_HALF, 1'b1, 1'b0));
      send_request(make_req(KIND_START, 1'b1, Q16_ONE, Q16_ONE, 1'b1, 1'b1));
      repeat (15) send_request(make_req(KIND_TICK, 1'b0, '0, '0, 1'b1, 1'b0));
      send_request(make_req(KIND_TICK, 1'b0, '0, '0, 1'b0, 1'b0));
   endtask

   task automatic test_slow_rate_manual_stop();
      send_request(make_req(KIND_START, 1'b1, '0, Q16_MAX, 1'b0, 1'b1));
      send_request(make_req(KIND_TICK, 1'b0, '0, '0, 1'b1, 1'b1));
      send_request(make_req(KIND_STOP, 1'b0, '0, '0, 1'b1, 1'b1));
   endtask

   task automatic test_endstop_stop();
      send_request(make_req(KIND_START, 1'b1, Q16_MAX, Q16_ONE, 1'b1, 1'b1));
      send_request(make_req(KIND_TICK, 1'b0, '0, '0, 1'b1, 1'b0));
   endtask

   task automatic run_job();
      logic        refill;
      logic [63:0] unit_vol;
      logic [63:0] flow_w;
      logic [31:0] vol;
      int          whole_steps;
      int          cap;
      int          n;
      logic        dir_lvl;
      logic        other_lvl;
      refill      = 1'($urandom_range(0, 1));
      whole_steps = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
      unit_vol    = (64'd1 << 40) / cfg_coef;
      flow_w      = (64'($urandom_range(300, 3000)) << 40) / cfg_coef;
      if (flow_w > 64'hFFFF_FFFF) flow_w = 64'hFFFF_FFFF;
      vol = 32'(64'(whole_steps) * unit_vol + 64'($urandom_range(0, 32'(unit_vol - 1))));
      dir_lvl   = ($urandom_range(0, 9) != 0);
      other_lvl = 1'($urandom_range(0, 1));
      send_request(make_req(KIND_START, refill, flow_w[31:0], vol,
                            refill ? other_lvl : dir_lvl, refill ? dir_lvl : other_lvl));
      cap = $urandom_range(1, 150);
      n   = 0;
      while (run_active && n < cap) begin
         dir_lvl   = ($urandom_range(0, 99) >= 2);
         other_lvl = 1'($urandom_range(0, 1));
         send_request(make_req(KIND_TICK, 1'($urandom_range(0, 1)), $urandom, $urandom,
                               run_backward ? other_lvl : dir_lvl,
                               run_backward ? dir_lvl : other_lvl));
         n++;
      end
      if (run_active && $urandom_range(0, 1))
         send_request(make_req(KIND_STOP, 1'($urandom_range(0, 1)), $urandom, $urandom,
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
   endtask

   task automatic test_random_jobs(input int n_items, input int idle_pct, input int stall_pct,
                                   input logic [31:0] coef, input logic invert);
      int   target;
      int   pause_at;
      logic paused;
      wait_drain();
      write_csr(CSR_COEF, coef);
      write_csr(CSR_INVERT, 32'(invert));
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target   = requests_sent + n_items;
      pause_at = requests_sent + n_items / 2;
      paused   = 1'b0;
      while (requests_sent < target) begin
         if (!paused && requests_sent >= pause_at) begin
            wait_drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 15)
            send_request(make_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                  $urandom, $urandom, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
         else
            run_job();
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_COEF;
      csr_data       = '0;
      error_count    = 0;
      requests_sent  = 0;
      quiet_cycles   = 0;
      send_idle_pct  = 37;
      recv_stall_pct = 72;
      cfg_coef       = '0;
      cfg_invert     = 1'b1;
      run_active     = 1'b0;
      run_backward   = 1'b0;
      step_cnt       = '0;
      step_lim       = '0;
      step_per       = 16'd1;
      tick_left      = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_idle_requests();
      test_refused_starts();
      test_zero_limit();
      wait_drain();
      write_csr(CSR_COEF, COEF_ONE);
      write_csr(CSR_INVERT, 32'd0);
      test_limit_with_endstop();
      test_slow_rate_manual_stop();
      test_endstop_stop();

      test_random_jobs(500, 37, 72, $urandom_range(COEF_ONE / 2, COEF_ONE * 4), 1'b1);
      test_random_jobs(500, 72, 37, COEF_MAX, 1'b0);
      test_random_jobs(500, 0, 0, COEF_SIXTEENTH, 1'b1);

      wait_drain();
      if (expected_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: dosing_step_pulse_controller_top.f
hdl/dspc_pkg.sv
hdl/dspc_front.sv
hdl/dspc_calc.sv
hdl/dspc_back.sv
hdl/dosing_step_pulse_controller_top.sv
tb/tb_dosing_step_pulse_controller_top.sv
